// ----- design/ostq_pkg.sv -----
// ----------------------------------------------------------------------------
// ostq_pkg
// Shared types and constants of the one-shot and periodic timer queue.
// ----------------------------------------------------------------------------
package ostq_pkg;

    localparam int SLOTS      = 16;
    localparam int TIME_BITS  = 32;
    localparam int TAG_BITS   = 8;
    localparam int DELAY_BITS = 31;
    localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_BITS   = $clog2(SLOTS + 1);

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_ADD_ONCE     = 2'd0,
        OP_ADD_PERIODIC = 2'd1,
        OP_TICK         = 2'd2
    } op_t;

    // result kinds of an output word
    typedef enum logic [1:0] {
        KIND_ADDED    = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_FIRED    = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_SCAN,
        ST_FIRE
    } state_t;

    // per-slot task data kept beside the deadline
    typedef struct packed {
        logic                  periodic;
        logic [DELAY_BITS-1:0] period;
        logic [TAG_BITS-1:0]   tag;
    } info_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic tick_start;
        logic scan_start;
        logic add_commit;
        logic fire_commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic running;
        logic scan_done;
        logic due_none;
        logic due_last;
        logic out_free;
    } sts_t;

endpackage

// ----- design/ostq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ostq_ctrl
// Sequencer: decodes an accepted word and steps the datapath through add,
// tick, slot scan and firing.
// ----------------------------------------------------------------------------
module ostq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     operation,
    output logic           in_stall,
    input  ostq_pkg::sts_t sts,
    output ostq_pkg::cmd_t cmd
);

    ostq_pkg::state_t state_reg;
    ostq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ostq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ostq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (operation)
                        ostq_pkg::OP_ADD_ONCE:     state_next = ostq_pkg::ST_ADD;
                        ostq_pkg::OP_ADD_PERIODIC: state_next = ostq_pkg::ST_ADD;
                        ostq_pkg::OP_TICK:         state_next = ostq_pkg::ST_TICK;
                        default:                   state_next = ostq_pkg::ST_IDLE;
                    endcase
                end
            end
            ostq_pkg::ST_ADD:
            begin
                if (sts.out_free)
                begin
                    cmd.add_commit = 1'b1;
                    state_next     = ostq_pkg::ST_IDLE;
                end
            end
            ostq_pkg::ST_TICK:
            begin
                cmd.tick_start = 1'b1;
                if (sts.running)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ostq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = ostq_pkg::ST_IDLE;
                end
            end
            ostq_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.due_none ? ostq_pkg::ST_IDLE : ostq_pkg::ST_FIRE;
                end
            end
            ostq_pkg::ST_FIRE:
            begin
                if (sts.out_free)
                begin
                    cmd.fire_commit = 1'b1;
                    if (sts.due_last)
                    begin
                        state_next = ostq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ostq_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ostq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ostq_dp.sv -----
// ----------------------------------------------------------------------------
// ostq_dp
// Datapath: time counter, slot memory, scan pipeline with one age compare,
// slot update and the output word register.
// ----------------------------------------------------------------------------
module ostq_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ostq_pkg::cmd_t                  cmd,
    output ostq_pkg::sts_t                  sts,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    input  logic [1:0]                      operation,
    input  logic [ostq_pkg::DELAY_BITS-1:0] delay,
    input  logic [ostq_pkg::DELAY_BITS-1:0] period,
    input  logic [ostq_pkg::TAG_BITS-1:0]   task_tag,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      kind,
    output logic [ostq_pkg::TAG_BITS-1:0]   fired_tag,
    output logic                            last
);

    localparam logic [ostq_pkg::IDX_BITS-1:0] LAST_IDX =
        ostq_pkg::IDX_BITS'(ostq_pkg::SLOTS - 1);

    // configuration and time
    logic                             running_reg;
    logic [ostq_pkg::TIME_BITS-1:0]   time_now_reg;

    // latched input word
    logic                             periodic_in_reg;
    logic [ostq_pkg::DELAY_BITS-1:0]  delay_in_reg;
    logic [ostq_pkg::DELAY_BITS-1:0]  period_in_reg;
    logic [ostq_pkg::TAG_BITS-1:0]    tag_in_reg;

    // slot flags and memories
    logic [ostq_pkg::SLOTS-1:0]       valid_reg;
    logic [ostq_pkg::SLOTS-1:0]       done_reg;
    logic [ostq_pkg::TIME_BITS-1:0]   deadline_mem [ostq_pkg::SLOTS];
    ostq_pkg::info_t                  info_mem [ostq_pkg::SLOTS];
    logic [ostq_pkg::TIME_BITS-1:0]   rd_deadline_reg;
    ostq_pkg::info_t                  rd_info_reg;

    // scan pipeline
    logic                             issue_reg;
    logic [ostq_pkg::IDX_BITS-1:0]    addr_reg;
    logic                             s1_vld_reg;
    logic [ostq_pkg::IDX_BITS-1:0]    s1_idx_reg;
    logic [ostq_pkg::TIME_BITS-1:0]   s1_age;
    logic                             s1_elig;
    logic                             s2_vld_reg;
    logic [ostq_pkg::IDX_BITS-1:0]    s2_idx_reg;
    logic [ostq_pkg::TIME_BITS-1:0]   s2_age_reg;
    logic                             s2_elig_reg;
    ostq_pkg::info_t                  s2_info_reg;
    logic                             scan_done_reg;

    // best candidate of the current round
    logic                             best_found_reg;
    logic [ostq_pkg::IDX_BITS-1:0]    best_idx_reg;
    logic [ostq_pkg::TIME_BITS-1:0]   best_age_reg;
    ostq_pkg::info_t                  best_info_reg;
    logic [ostq_pkg::CNT_BITS-1:0]    due_cnt_reg;

    // free slot search and memory write port
    logic                             any_free;
    logic [ostq_pkg::IDX_BITS-1:0]    free_idx;
    logic                             add_write;
    logic                             rearm_write;
    logic [ostq_pkg::IDX_BITS-1:0]    wr_idx;
    logic [ostq_pkg::TIME_BITS-1:0]   wr_deadline;
    ostq_pkg::info_t                  wr_info;

    // output word register
    logic                             out_valid_reg;
    logic [1:0]                       kind_reg;
    logic [ostq_pkg::TAG_BITS-1:0]    tag_out_reg;
    logic                             last_reg;
    logic                             out_free;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            running_reg <= cfg_data;
        end
    end

    // time counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg <= '0;
        end
        else if (cmd.tick_start)
        begin
            time_now_reg <= time_now_reg + ostq_pkg::TIME_BITS'(1);
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            periodic_in_reg <= (operation == ostq_pkg::OP_ADD_PERIODIC);
            delay_in_reg    <= delay;
            period_in_reg   <= period;
            tag_in_reg      <= task_tag;
        end
    end

    // lowest free slot
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = ostq_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = ostq_pkg::IDX_BITS'(i);
            end
        end
    end

    // memory write port, shared by add and periodic re-arm
    assign add_write   = cmd.add_commit & any_free;
    assign rearm_write = cmd.fire_commit & best_info_reg.periodic;
    assign wr_idx      = add_write ? free_idx : best_idx_reg;
    assign wr_deadline = add_write
                         ? time_now_reg + ostq_pkg::TIME_BITS'(delay_in_reg)
                         : time_now_reg + ostq_pkg::TIME_BITS'(best_info_reg.period);

    always_comb
    begin
        wr_info.periodic = periodic_in_reg;
        wr_info.period   = periodic_in_reg ? period_in_reg : '0;
        wr_info.tag      = tag_in_reg;
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (add_write || rearm_write)
        begin
            deadline_mem[wr_idx] <= wr_deadline;
        end
        if (add_write)
        begin
            info_mem[wr_idx] <= wr_info;
        end
        rd_deadline_reg <= deadline_mem[addr_reg];
        rd_info_reg     <= info_mem[addr_reg];
    end

    // slot valid and fired-this-tick flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= '0;
        end
        else
        begin
            if (add_write)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.fire_commit && !best_info_reg.periodic)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.tick_start)
            begin
                done_reg <= '0;
            end
            else if (cmd.fire_commit)
            begin
                done_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // scan address sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            addr_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                issue_reg <= 1'b1;
                addr_reg  <= '0;
            end
            else if (issue_reg)
            begin
                if (addr_reg == LAST_IDX)
                begin
                    issue_reg <= 1'b0;
                end
                addr_reg <= addr_reg + ostq_pkg::IDX_BITS'(1);
            end
            s1_vld_reg <= issue_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= addr_reg;
    end

    // wrap-aware age; due when the top bit is clear
    assign s1_age  = time_now_reg - rd_deadline_reg;
    assign s1_elig = valid_reg[s1_idx_reg] & ~done_reg[s1_idx_reg]
                     & ~s1_age[ostq_pkg::TIME_BITS-1];

    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_age_reg  <= s1_age;
        s2_elig_reg <= s1_elig;
        s2_info_reg <= rd_info_reg;
    end

    // oldest due slot, ties kept by the lower slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            due_cnt_reg    <= '0;
            scan_done_reg  <= 1'b0;
        end
        else
        begin
            scan_done_reg <= s2_vld_reg && (s2_idx_reg == LAST_IDX);
            if (cmd.scan_start)
            begin
                best_found_reg <= 1'b0;
                due_cnt_reg    <= '0;
            end
            else if (s2_vld_reg && s2_elig_reg)
            begin
                due_cnt_reg <= due_cnt_reg + ostq_pkg::CNT_BITS'(1);
                if (!best_found_reg || (s2_age_reg > best_age_reg))
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg && s2_elig_reg && (!best_found_reg || (s2_age_reg > best_age_reg)))
        begin
            best_idx_reg  <= s2_idx_reg;
            best_age_reg  <= s2_age_reg;
            best_info_reg <= s2_info_reg;
        end
    end

    // output word register
    assign out_free = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.add_commit || cmd.fire_commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_commit)
        begin
            kind_reg    <= any_free ? ostq_pkg::KIND_ADDED : ostq_pkg::KIND_REJECTED;
            tag_out_reg <= tag_in_reg;
            last_reg    <= 1'b1;
        end
        else if (cmd.fire_commit)
        begin
            kind_reg    <= ostq_pkg::KIND_FIRED;
            tag_out_reg <= best_info_reg.tag;
            last_reg    <= (due_cnt_reg == ostq_pkg::CNT_BITS'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = tag_out_reg;
    assign last      = last_reg;

    // status to the controller
    always_comb
    begin
        sts.running   = running_reg;
        sts.scan_done = scan_done_reg;
        sts.due_none  = (due_cnt_reg == '0);
        sts.due_last  = (due_cnt_reg == ostq_pkg::CNT_BITS'(1));
        sts.out_free  = out_free;
    end

endmodule

// ----- design/one_shot_periodic_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_queue_unit
// Timer table of one-shot and periodic tasks driven by tick words.
// ----------------------------------------------------------------------------
// One word is handled at a time. An add word waits in the add state for a
// free output register and returns one result. A tick word advances time in
// the tick state; while running, each due task then costs one sweep of the
// slot memory through a single age comparator, and each firing waits for a
// free output register. A tick with nothing due still needs one sweep when
// running. The output register lets the block take the next word while the
// last result waits. Configuration writes are taken at any time but must
// only be issued while the block is idle.
module one_shot_periodic_timer_queue_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [ostq_pkg::DELAY_BITS-1:0] delay,
    input  logic [ostq_pkg::DELAY_BITS-1:0] period,
    input  logic [ostq_pkg::TAG_BITS-1:0]   task_tag,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      kind,
    output logic [ostq_pkg::TAG_BITS-1:0]   fired_tag,
    output logic                            last
);

    ostq_pkg::cmd_t cmd;
    ostq_pkg::sts_t sts;

    // sequencer
    ostq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot storage and scan datapath
    ostq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .operation (operation),
        .delay     (delay),
        .period    (period),
        .task_tag  (task_tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .fired_tag (fired_tag),
        .last      (last)
    );

endmodule

// ----- tb/one_shot_periodic_timer_queue_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_queue_unit_tb
// Self-checking bench for the one-shot and periodic timer queue.
// A mirror of the timer table predicts every result word from the accepted
// input words. The result stream is compared in order against those
// predictions. Directed words cover the field extremes, zero delay and zero
// period, far deadlines, the unused operation and a full table. Random phases
// alternate the running register; most apply random idle on both sides.
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_queue_unit_tb;

    // cycles to let a sweep with no result finish before touching the register
    localparam int QUIET_CYCLES    = 2 + ostq_pkg::SLOTS * (ostq_pkg::SLOTS + 4) + 60;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 16;

    localparam logic [1:0]                      OP_UNUSED = 2'd3;
    localparam logic [ostq_pkg::DELAY_BITS-1:0] DELAY_MAX = '1;

    typedef struct {
        ostq_pkg::kind_t               kind;
        logic [ostq_pkg::TAG_BITS-1:0] tag;
        logic                          last;
    } result_t;

    // mirror of the timer table and the result words it predicts
    class timer_table_mirror;
        bit                              running;
        logic [ostq_pkg::TIME_BITS-1:0]  now;
        bit                              used [ostq_pkg::SLOTS];
        logic [ostq_pkg::TIME_BITS-1:0]  deadline [ostq_pkg::SLOTS];
        logic [ostq_pkg::DELAY_BITS-1:0] period_of [ostq_pkg::SLOTS];
        bit                              periodic [ostq_pkg::SLOTS];
        logic [ostq_pkg::TAG_BITS-1:0]   tag_of [ostq_pkg::SLOTS];
        result_t                         expected_results [$];
        int                              errors;
        int                              words;
        int                              added;
        int                              rejected;
        int                              fired;

        function new();
            running  = 1'b0;
            now      = '0;
            errors   = 0;
            words    = 0;
            added    = 0;
            rejected = 0;
            fired    = 0;
            foreach (used[i])
                used[i] = 1'b0;
        endfunction

        function void push_result(ostq_pkg::kind_t k, logic [ostq_pkg::TAG_BITS-1:0] t,
                                  logic l);
            result_t r;
            r.kind = k;
            r.tag  = t;
            r.last = l;
            expected_results.push_back(r);
        endfunction

        // note one accepted input word and predict the words it causes
        function void apply_word(logic [1:0] op, logic [ostq_pkg::DELAY_BITS-1:0] dly,
                                 logic [ostq_pkg::DELAY_BITS-1:0] per,
                                 logic [ostq_pkg::TAG_BITS-1:0] tag);
            int                             free_slot;
            int                             best;
            int                             count;
            logic [ostq_pkg::TIME_BITS-1:0] age;
            logic [ostq_pkg::TIME_BITS-1:0] best_age;
            bit                             done [ostq_pkg::SLOTS];
            words++;
            if (op == ostq_pkg::OP_ADD_ONCE || op == ostq_pkg::OP_ADD_PERIODIC)
            begin
                free_slot = -1;
                for (int i = ostq_pkg::SLOTS - 1; i >= 0; i--)
                    if (!used[i])
                        free_slot = i;
                if (free_slot < 0)
                begin
                    push_result(ostq_pkg::KIND_REJECTED, tag, 1'b1);
                    rejected++;
                end
                else
                begin
                    used[free_slot]      = 1'b1;
                    deadline[free_slot]  = now + ostq_pkg::TIME_BITS'(dly);
                    periodic[free_slot]  = (op == ostq_pkg::OP_ADD_PERIODIC);
                    period_of[free_slot] = (op == ostq_pkg::OP_ADD_PERIODIC) ? per : '0;
                    tag_of[free_slot]    = tag;
                    push_result(ostq_pkg::KIND_ADDED, tag, 1'b1);
                    added++;
                end
            end
            else if (op == ostq_pkg::OP_TICK)
            begin
                now = now + 1'b1;
                if (running)
                begin
                    foreach (done[i])
                        done[i] = 1'b0;
                    count = 0;
                    best  = 0;
                    // fire due slots oldest first, each at most once per tick
                    while (best >= 0)
                    begin
                        best     = -1;
                        best_age = '0;
                        for (int i = 0; i < ostq_pkg::SLOTS; i++)
                        begin
                            if (used[i] && !done[i])
                            begin
                                age = now - deadline[i];
                                if (!age[ostq_pkg::TIME_BITS-1] &&
                                    (best < 0 || age > best_age))
                                begin
                                    best     = i;
                                    best_age = age;
                                end
                            end
                        end
                        if (best >= 0)
                        begin
                            done[best] = 1'b1;
                            push_result(ostq_pkg::KIND_FIRED, tag_of[best], 1'b0);
                            count++;
                            fired++;
                            if (periodic[best])
                                deadline[best] = now + ostq_pkg::TIME_BITS'(period_of[best]);
                            else
                                used[best] = 1'b0;
                        end
                    end
                    if (count > 0)
                        expected_results[expected_results.size() - 1].last = 1'b1;
                end
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void compare_result(logic [1:0] k, logic [ostq_pkg::TAG_BITS-1:0] t,
                                     logic l);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d fired_tag %0d last %0d",
                       k, t, l);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (k !== exp_r.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", exp_r.kind, k);
                    errors++;
                end
                if (t !== exp_r.tag)
                begin
                    $error("fired_tag mismatch: expected %0d, actual %0d", exp_r.tag, t);
                    errors++;
                end
                if (l !== exp_r.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", exp_r.last, l);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [1:0]                      operation;
    logic [ostq_pkg::DELAY_BITS-1:0] delay;
    logic [ostq_pkg::DELAY_BITS-1:0] period;
    logic [ostq_pkg::TAG_BITS-1:0]   task_tag;
    logic                            out_valid;
    logic                            out_stall;
    logic [1:0]                      kind;
    logic [ostq_pkg::TAG_BITS-1:0]   fired_tag;
    logic                            last;

    timer_table_mirror mirror;
    bit                no_idle;
    int                settings_written;

    one_shot_periodic_timer_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .delay     (delay),
        .period    (period),
        .task_tag  (task_tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .fired_tag (fired_tag),
        .last      (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // send one input word after a random gap
    task automatic send_word(logic [1:0] op, logic [ostq_pkg::DELAY_BITS-1:0] dly,
                             logic [ostq_pkg::DELAY_BITS-1:0] per,
                             logic [ostq_pkg::TAG_BITS-1:0] tag);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operation <= op;
        delay     <= dly;
        period    <= per;
        task_tag  <= tag;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        mirror.apply_word(op, dly, per, tag);
    endtask

    // stop sending and wait for every predicted word to come back
    task automatic wait_results_clear();
        @(negedge clk);
        in_valid <= 1'b0;
        while (mirror.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // as above, then let any sweep without results finish
    task automatic drain_results();
        wait_results_clear();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // write the running register
    task automatic write_running(logic value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        mirror.running = value;
        settings_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random word; ignored words are flagged so they are not counted
    task automatic random_word(output bit counted);
        int                              pick;
        logic [1:0]                      op;
        logic [ostq_pkg::DELAY_BITS-1:0] dly;
        logic [ostq_pkg::DELAY_BITS-1:0] per;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            op = OP_UNUSED;
        else if (pick < 50)
            op = ostq_pkg::OP_TICK;
        else if (pick < 91)
            op = ostq_pkg::OP_ADD_ONCE;
        else
            op = ostq_pkg::OP_ADD_PERIODIC;
        // mostly near deadlines, now and then a far one
        if ($urandom_range(0, 99) < 3)
            dly = ostq_pkg::DELAY_BITS'($urandom);
        else
            dly = ostq_pkg::DELAY_BITS'($urandom_range(0, 10));
        if (op == ostq_pkg::OP_ADD_PERIODIC && $urandom_range(0, 99) >= 10)
            per = ostq_pkg::DELAY_BITS'($urandom_range(0, 6));
        else
            per = ostq_pkg::DELAY_BITS'($urandom);
        send_word(op, dly, per, ostq_pkg::TAG_BITS'($urandom_range(0, 255)));
        counted = (op != OP_UNUSED);
    endtask

    // result side: random stall, then take and check one word
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            mirror.compare_result(kind, fired_tag, last);
        end
    end

    // main sequence
    initial
    begin
        int n;
        bit counted;
        mirror           = new();
        settings_written = 0;
        no_idle          = 1'b0;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = 1'b0;
        in_valid         = 1'b0;
        operation        = ostq_pkg::OP_TICK;
        delay            = '0;
        period           = '0;
        task_tag         = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero delay with an ignored maximal period
        write_running(1'b1);
        send_word(ostq_pkg::OP_ADD_ONCE, '0, DELAY_MAX, 8'h00);
        send_word(ostq_pkg::OP_TICK, '0, '0, 8'h00);
        // zero period fires on every tick, once per tick
        send_word(ostq_pkg::OP_ADD_PERIODIC, ostq_pkg::DELAY_BITS'(1), '0, 8'hFF);
        send_word(ostq_pkg::OP_TICK, '0, '0, 8'h00);
        send_word(ostq_pkg::OP_TICK, '0, '0, 8'h00);
        send_word(ostq_pkg::OP_TICK, '0, '0, 8'h00);
        // far deadline stays not due across the half range
        send_word(ostq_pkg::OP_ADD_ONCE, DELAY_MAX, '0, 8'h5A);
        // maximal period fires once then parks far ahead
        send_word(ostq_pkg::OP_ADD_PERIODIC, '0, DELAY_MAX, 8'hA5);
        send_word(ostq_pkg::OP_TICK, '0, '0, 8'h00);
        // unused operation is dropped
        send_word(OP_UNUSED, DELAY_MAX, DELAY_MAX, 8'hFF);
        // fill the table, the last add is rejected
        for (int i = 0; i < 14; i++)
            send_word(ostq_pkg::OP_ADD_ONCE, ostq_pkg::DELAY_BITS'(i % 3),
                      ostq_pkg::DELAY_BITS'($urandom), ostq_pkg::TAG_BITS'(8'h10 + i));
        // ties and ordering as the fill entries come due
        repeat (3) send_word(ostq_pkg::OP_TICK, '0, '0, 8'h00);

        // random phases, running held and released in turn
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            write_running(p[0]);
            no_idle = (p % 3 == 2);
            n = 0;
            while (n < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_results_clear();
                random_word(counted);
                if (counted)
                    n++;
            end
        end

        drain_results();
        $display("covered %0d words: %0d adds taken, %0d adds refused, %0d firings",
                 mirror.words, mirror.added, mirror.rejected, mirror.fired);
        $display("running register written %0d times, held and released", settings_written);
        if (mirror.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
